// ----- rtl/mfc_pkg.sv -----
`default_nettype none

package mfc_pkg;

    localparam int unsigned ADDR_W  = 48;
    localparam int unsigned POS_W   = 17;
    localparam int unsigned LEN_W   = 16;

    localparam logic [7:0]       END_BYTE    = 8'hFD;
    localparam logic [POS_W-1:0] HDR_LAST    = 17'd23;
    localparam logic [POS_W-1:0] HDR_CHECK   = 17'd24;
    localparam logic [POS_W-1:0] BODY_START  = 17'd25;
    localparam logic [POS_W-1:0] FRAME_EXTRA = 17'd28;

    typedef enum logic [0:0] {
        REG_HOST_ADDR = 1'b0,
        REG_TERM_ADDR = 1'b1
    } t_reg_index;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ADDR_BAD  = 3'd1,
        ST_TOO_SHORT = 3'd2,
        ST_SUM_BAD   = 3'd3,
        ST_END_BAD   = 3'd4
    } t_status;

    typedef struct packed {
        logic             valid;
        t_status          status;
        logic [POS_W-1:0] frame_length;
    } t_verdict;

endpackage

`default_nettype wire

// ----- rtl/mfc_core.sv -----
`default_nettype none

module mfc_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic [7:0]                  i_byte,
    input  wire logic                        i_last,
    input  wire logic [mfc_pkg::ADDR_W-1:0]  i_host_addr,
    input  wire logic [mfc_pkg::ADDR_W-1:0]  i_term_addr,
    output mfc_pkg::t_verdict                o_verdict
);
    import mfc_pkg::*;

    logic [POS_W-1:0]  r_pos,     n_pos;
    logic [7:0]        r_hsum,    n_hsum;
    logic [7:0]        r_bsum,    n_bsum;
    logic [LEN_W-1:0]  r_len,     n_len;
    logic [ADDR_W-1:0] r_src,     n_src;
    logic [ADDR_W-1:0] r_dst,     n_dst;
    t_status           r_verdict, n_verdict;
    logic              r_fixed,   n_fixed;

    logic [POS_W-1:0]  body_end;
    logic [POS_W-1:0]  full_len;

    always_comb begin
        n_hsum    = r_hsum;
        n_bsum    = r_bsum;
        n_len     = r_len;
        n_src     = r_src;
        n_dst     = r_dst;
        n_verdict = r_verdict;
        n_fixed   = r_fixed;
        body_end  = {1'b0, r_len} + BODY_START;

        if (r_pos >= 17'd1 && r_pos <= HDR_LAST) begin
            n_hsum = r_hsum + i_byte;
        end
        if (r_pos >= 17'd2 && r_pos <= 17'd7) begin
            n_src = {i_byte, r_src[ADDR_W-1:8]};
        end
        if (r_pos >= 17'd8 && r_pos <= 17'd13) begin
            n_dst = {i_byte, r_dst[ADDR_W-1:8]};
        end
        if (r_pos == 17'd13 && !r_fixed &&
            (n_src != i_host_addr || n_dst != i_term_addr)) begin
            n_verdict = ST_ADDR_BAD;
            n_fixed   = 1'b1;
        end
        if (r_pos == 17'd15) begin
            n_len = {r_len[15:8], i_byte};
        end
        if (r_pos == 17'd16) begin
            n_len = {i_byte, r_len[7:0]};
        end
        if (r_pos == HDR_CHECK && !r_fixed && i_byte != (~r_hsum + 8'd1)) begin
            n_verdict = ST_SUM_BAD;
            n_fixed   = 1'b1;
        end
        if (!r_fixed && r_pos >= BODY_START) begin
            if (r_pos < body_end) begin
                n_bsum = r_bsum + i_byte;
            end else if (r_pos == body_end) begin
                if (r_verdict == ST_OK && i_byte != (~r_bsum + 8'd1)) begin
                    n_verdict = ST_SUM_BAD;
                end
            end else if (r_pos == body_end + 17'd1 || r_pos == body_end + 17'd2) begin
                if (r_verdict == ST_OK && i_byte != END_BYTE) begin
                    n_verdict = ST_END_BAD;
                end
            end
        end

        n_pos    = (r_pos != '1) ? r_pos + 17'd1 : r_pos;
        full_len = {1'b0, n_len} + FRAME_EXTRA;

        o_verdict.valid = i_step && i_last;
        if (n_fixed) begin
            o_verdict.status       = n_verdict;
            o_verdict.frame_length = n_pos;
        end else if (n_pos < BODY_START) begin
            o_verdict.status       = ST_TOO_SHORT;
            o_verdict.frame_length = n_pos;
        end else if (n_pos < full_len) begin
            o_verdict.status       = ST_TOO_SHORT;
            o_verdict.frame_length = full_len;
        end else begin
            o_verdict.status       = n_verdict;
            o_verdict.frame_length = full_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_pos     <= '0;
            r_hsum    <= '0;
            r_bsum    <= '0;
            r_len     <= '0;
            r_src     <= '0;
            r_dst     <= '0;
            r_verdict <= ST_OK;
            r_fixed   <= 1'b0;
        end else if (i_step) begin
            r_pos     <= n_pos;
            r_hsum    <= n_hsum;
            r_bsum    <= n_bsum;
            r_len     <= n_len;
            r_src     <= n_src;
            r_dst     <= n_dst;
            r_verdict <= n_verdict;
            r_fixed   <= n_fixed;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/meter_frame_checker.sv -----
`default_nettype none

// Checks a received meter-link buffer fed one byte per word, start byte first, and
// gives one verdict word (status and frame length) once the tlast word is accepted.
// A byte is taken every clock cycle while no verdict waits or the downstream side
// takes it in the same cycle; each byte passes through one add/compare step against
// the running frame state, and the verdict sits in an output register.
// Host and terminal addresses are written through the configuration port; the user
// must do so only while no buffer is in progress, as the block does not enforce it.

module meter_frame_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [7:0]                  s_axis_tdata,  // [7:0] rx_byte
    input  wire logic                        s_axis_tlast,  // last_byte
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [23:0]                      m_axis_tdata,  // [2:0] status, [19:3] frame_length
    input  wire logic                        i_cfg_we,
    input  wire logic [0:0]                  i_cfg_index,
    input  wire logic [mfc_pkg::ADDR_W-1:0]  i_cfg_data
);
    import mfc_pkg::*;

    logic [ADDR_W-1:0] r_host_addr;
    logic [ADDR_W-1:0] r_term_addr;
    logic              r_out_valid;
    t_status           r_status;
    logic [POS_W-1:0]  r_length;
    logic              step;
    t_verdict          verdict;

    assign s_axis_tready = i_rst_n && (!r_out_valid || m_axis_tready);
    assign step          = s_axis_tvalid && s_axis_tready;

    mfc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_host_addr (r_host_addr),
        .i_term_addr (r_term_addr),
        .o_verdict   (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_addr <= '0;
            r_term_addr <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_HOST_ADDR: r_host_addr <= i_cfg_data;
                REG_TERM_ADDR: r_term_addr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (verdict.valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (verdict.valid) begin
            r_status <= verdict.status;
            r_length <= verdict.frame_length;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_length, r_status};

endmodule

`default_nettype wire

// ----- rtl/mfc_checker.sv -----
`default_nettype none

module mfc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata
);
    import mfc_pkg::*;

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("verdict word present after reset");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= ST_END_BAD)
        else $error("status code out of range");

    a_ok_full_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[2:0] == ST_OK) |-> m_axis_tdata[19:3] >= FRAME_EXTRA)
        else $error("ok verdict on a frame shorter than its overhead");

    a_verdict_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
        else $error("verdict word without a closing input word");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled verdict word changed");

endmodule

bind meter_frame_checker mfc_checker u_mfc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import mfc_pkg::*;

    typedef logic [7:0] t_byte_q[$];

    typedef struct {
        t_status          status;
        logic [POS_W-1:0] flen;
    } t_frame_verdict;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;    // [7:0] rx_byte
    logic              s_axis_tlast;    // last_byte
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;    // [2:0] status, [19:3] frame_length
    logic              i_cfg_we;
    logic [0:0]        i_cfg_index;
    logic [ADDR_W-1:0] i_cfg_data;

    meter_frame_checker u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // frame tracking state, mirrors the checker
    logic [POS_W-1:0]  byte_pos  = '0;
    logic [7:0]        hdr_sum   = '0;
    logic [7:0]        body_sum  = '0;
    logic [LEN_W-1:0]  body_len  = '0;
    logic [ADDR_W-1:0] src_acc   = '0;
    logic [ADDR_W-1:0] dst_acc   = '0;
    logic [ADDR_W-1:0] host_q    = '0;
    logic [ADDR_W-1:0] term_q    = '0;
    t_status           fail_code = ST_OK;
    logic              hard_fail = 1'b0;

    t_frame_verdict    pending_verdicts[$];
    int unsigned       err_cnt    = 0;
    logic              idle_on    = 1'b1;
    int unsigned       stall_left = 0;

    function automatic int unsigned gap_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ADDR_W-1:0];
    endfunction

    task automatic track_frame_byte(input logic [7:0] b, input logic last);
        int unsigned    p;
        int unsigned    len;
        int unsigned    full;
        logic [7:0]     neg;
        t_frame_verdict v;
        p   = byte_pos;
        len = body_len;
        if (p >= 1 && p <= HDR_LAST)
            hdr_sum = hdr_sum + b;
        if (p >= 2 && p <= 7)
            src_acc[8*(p-2) +: 8] = b;
        if (p >= 8 && p <= 13)
            dst_acc[8*(p-8) +: 8] = b;
        if (p == 13 && !hard_fail && (src_acc != host_q || dst_acc != term_q)) begin
            fail_code = ST_ADDR_BAD;
            hard_fail = 1'b1;
        end
        if (p == 15)
            body_len[7:0] = b;
        if (p == 16)
            body_len[15:8] = b;
        neg = -hdr_sum;
        if (p == HDR_CHECK && !hard_fail && b != neg) begin
            fail_code = ST_SUM_BAD;
            hard_fail = 1'b1;
        end
        if (!hard_fail && p >= BODY_START) begin
            neg = -body_sum;
            if (p < BODY_START + len) begin
                body_sum = body_sum + b;
            end else if (p == BODY_START + len) begin
                if (fail_code == ST_OK && b != neg)
                    fail_code = ST_SUM_BAD;
            end else if (p == BODY_START + 1 + len || p == BODY_START + 2 + len) begin
                if (fail_code == ST_OK && b != END_BYTE)
                    fail_code = ST_END_BAD;
            end
        end
        if (byte_pos != '1)
            byte_pos = byte_pos + 1'b1;
        if (last) begin
            full = body_len + FRAME_EXTRA;
            if (hard_fail) begin
                v.status = fail_code;
                v.flen   = byte_pos;
            end else if (byte_pos < BODY_START) begin
                v.status = ST_TOO_SHORT;
                v.flen   = byte_pos;
            end else if (byte_pos < full) begin
                v.status = ST_TOO_SHORT;
                v.flen   = POS_W'(full);
            end else begin
                v.status = fail_code;
                v.flen   = POS_W'(full);
            end
            pending_verdicts.push_back(v);
            byte_pos  = '0;
            hdr_sum   = '0;
            body_sum  = '0;
            body_len  = '0;
            src_acc   = '0;
            dst_acc   = '0;
            fail_code = ST_OK;
            hard_fail = 1'b0;
        end
    endtask

    function automatic t_byte_q build_frame(input logic [ADDR_W-1:0] src,
                                            input logic [ADDR_W-1:0] dst,
                                            input logic [LEN_W-1:0] blen);
        t_byte_q    f;
        logic [7:0] s;
        logic [7:0] b;
        f.push_back(8'($urandom_range(0, 255)));        // start
        f.push_back(8'($urandom_range(0, 255)));        // version
        for (int i = 0; i < 6; i++)
            f.push_back(src[8*i +: 8]);
        for (int i = 0; i < 6; i++)
            f.push_back(dst[8*i +: 8]);
        f.push_back(8'($urandom_range(0, 255)));        // message id
        f.push_back(blen[7:0]);
        f.push_back(blen[15:8]);
        for (int i = 0; i < 7; i++)                     // type, timestamp
            f.push_back(8'($urandom_range(0, 255)));
        s = '0;
        for (int i = 1; i <= HDR_LAST; i++)
            s = s + f[i];
        f.push_back(-s);
        s = '0;
        for (int i = 0; i < blen; i++) begin
            b = 8'($urandom_range(0, 255));
            s = s + b;
            f.push_back(b);
        end
        f.push_back(-s);
        f.push_back(END_BYTE);
        f.push_back(END_BYTE);
        return f;
    endfunction

    task automatic send_word(input logic [7:0] b, input logic last);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 99) < 30) begin
            s_axis_tvalid = 1'b0;
            repeat (gap_len()) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tlast  = last;
        do @(posedge i_clk); while (!s_axis_tready);
        track_frame_byte(b, last);
    endtask

    task automatic send_buffer(input t_byte_q fr);
        foreach (fr[i])
            send_word(fr[i], i == fr.size() - 1);
    endtask

    task automatic drain();
        int unsigned waited;
        waited = 0;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_verdicts.size() != 0 && waited < 5000) begin
            @(negedge i_clk);
            waited++;
        end
        if (pending_verdicts.size() != 0) begin
            $error("verdicts never arrived: %0d outstanding", pending_verdicts.size());
            err_cnt++;
            pending_verdicts.delete();
        end
    endtask

    task automatic set_addresses(input logic [ADDR_W-1:0] host, input logic [ADDR_W-1:0] term);
        drain();
        repeat (4) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = REG_HOST_ADDR;
        i_cfg_data  = host;
        @(negedge i_clk);
        i_cfg_index = REG_TERM_ADDR;
        i_cfg_data  = term;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        host_q      = host;
        term_q      = term;
    endtask

    // addresses still zero from reset
    task automatic test_defaults();
        t_byte_q fr;
        send_buffer(build_frame('0, '0, 0));
        fr = {8'h68};
        send_buffer(fr);
        send_buffer(build_frame('0, '0, 3));
    endtask

    task automatic test_addresses();
        t_byte_q fr;
        set_addresses(rand_addr(), rand_addr());
        send_buffer(build_frame(host_q, term_q, 5));
        fr = build_frame(host_q, term_q, 5);
        fr[4] ^= 8'h10;
        send_buffer(fr);
        fr = build_frame(host_q, term_q, 5);
        fr[13] ^= 8'h80;
        send_buffer(fr);
        fr = fr[0:13];                                  // ends on last dest byte
        send_buffer(fr);
        fr = build_frame(host_q, term_q, 5);
        send_buffer(fr[0:12]);
        send_buffer(fr[0:13]);
    endtask

    task automatic test_checksums();
        t_byte_q fr;
        set_addresses('1, '0);
        fr = build_frame(host_q, term_q, 4);
        fr[HDR_CHECK] ^= 8'h01;
        send_buffer(fr);
        fr = build_frame(host_q, term_q, 4);
        fr[BODY_START + 4] ^= 8'hFF;
        send_buffer(fr);
        fr = build_frame(host_q, term_q, 4);
        fr[BODY_START + 5] ^= 8'h02;
        send_buffer(fr);
        fr = build_frame(host_q, term_q, 4);
        fr[BODY_START + 6] ^= 8'h20;
        send_buffer(fr);
        // body sum and end byte both bad: body sum reported
        fr = build_frame(host_q, term_q, 2);
        fr[BODY_START + 2] ^= 8'h04;
        fr[BODY_START + 3] ^= 8'h04;
        send_buffer(fr);
    endtask

    task automatic test_truncation();
        t_byte_q fr;
        set_addresses('0, '1);
        fr = build_frame(host_q, term_q, 10);
        send_buffer(fr[0:24]);
        fr[BODY_START + 10] ^= 8'h40;
        send_buffer(fr[0:36]);
        fr = build_frame(host_q, term_q, 16'hFFFF);
        send_buffer(fr[0:39]);
        fr = build_frame(host_q, term_q, 0);
        send_buffer(fr[0:23]);
        fr[HDR_CHECK] ^= 8'h08;
        send_buffer(fr[0:24]);
    endtask

    task automatic test_trailing();
        t_byte_q fr;
        set_addresses(rand_addr(), rand_addr());
        fr = build_frame(host_q, term_q, 7);
        repeat (5) fr.push_back(8'($urandom_range(0, 255)));
        send_buffer(fr);
        fr = build_frame(host_q, term_q, 1);
        fr[BODY_START + 3] = 8'h00;
        repeat (3) fr.push_back(END_BYTE);
        send_buffer(fr);
        fr = build_frame(~host_q, term_q, 0);
        repeat (4) fr.push_back(8'($urandom_range(0, 255)));
        send_buffer(fr);
    endtask

    task automatic test_random_phase(input logic [ADDR_W-1:0] host,
                                     input logic [ADDR_W-1:0] term);
        t_byte_q     fr;
        int unsigned bytes_sent;
        int unsigned r;
        int unsigned blen;
        int unsigned k;
        logic [7:0]  nz;
        set_addresses(host, term);
        bytes_sent = 0;
        while (bytes_sent < 200) begin
            idle_on = ($urandom_range(0, 9) != 0);
            r    = $urandom_range(0, 99);
            blen = ($urandom_range(0, 29) == 0) ? $urandom_range(65, 400)
                                                : $urandom_range(0, 40);
            nz   = 8'($urandom_range(1, 255));
            fr   = build_frame(host_q, term_q, LEN_W'(blen));
            if (r < 8)
                fr[$urandom_range(2, 7)] ^= nz;
            else if (r < 14)
                fr[$urandom_range(8, 13)] ^= nz;
            else if (r < 22)
                fr[HDR_CHECK] ^= nz;
            else if (r < 30)
                fr[BODY_START + blen] ^= nz;
            else if (r < 38)
                fr[$urandom_range(26, 27) + blen] ^= nz;
            else if (r < 46) begin
                fr.delete();
                repeat ($urandom_range(1, 40)) fr.push_back(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 5) == 0) begin
                k  = $urandom_range(0, fr.size() - 1);
                fr = fr[0:k];
            end
            if ($urandom_range(0, 6) == 0)
                repeat ($urandom_range(1, 8)) fr.push_back(8'($urandom_range(0, 255)));
            send_buffer(fr);
            bytes_sent += fr.size();
            if ($urandom_range(0, 19) == 0)
                drain();
        end
        idle_on = 1'b1;
    endtask

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 99) < 20) begin
            m_axis_tready <= 1'b0;
            stall_left    <= gap_len() - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_verdict
        t_frame_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_verdicts.size() == 0) begin
                $error("unexpected verdict word: status %0d, frame_length %0d",
                       m_axis_tdata[2:0], m_axis_tdata[19:3]);
                err_cnt++;
            end else begin
                want = pending_verdicts.pop_front();
                if (m_axis_tdata[2:0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tdata[2:0]);
                    err_cnt++;
                end
                if (m_axis_tdata[19:3] !== want.flen) begin
                    $error("frame_length: expected %0d, got %0d",
                           want.flen, m_axis_tdata[19:3]);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_HOST_ADDR;
        i_cfg_data    = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_defaults();
        test_addresses();
        test_checksums();
        test_truncation();
        test_trailing();
        test_random_phase(rand_addr(), rand_addr());
        test_random_phase('0, '1);
        test_random_phase('1, '0);
        test_random_phase(rand_addr(), rand_addr());

        drain();
        repeat (20) @(negedge i_clk);
        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- meter_frame_checker.f -----
rtl/mfc_pkg.sv
rtl/mfc_core.sv
rtl/meter_frame_checker.sv
rtl/mfc_checker.sv
dv/tb.sv
